[hdl/dtt_pkg.sv]
`default_nettype none

package dtt_pkg;

  // field widths
  localparam int unsigned SlotW  = 6;
  localparam int unsigned SecW   = 32;
  localparam int unsigned NsW    = 30;
  localparam int unsigned DlW    = SecW + NsW;
  localparam int unsigned MsW    = 42;
  localparam int unsigned InDataW  = 136;
  localparam int unsigned OutDataW = 120;

  // default table depth
  localparam int unsigned SlotsDefault = 64;

  // time constants
  localparam logic [NsW-1:0] NsPerS  = 30'd1000000000;
  localparam logic [19:0]    NsPerMs = 20'd1000000;

  // item kinds
  localparam logic OpSet   = 1'b0;
  localparam logic OpQuery = 1'b1;

  // result status codes
  localparam logic StOk       = 1'b0;
  localparam logic StNotFound = 1'b1;

  // table update strobes
  typedef struct packed {
    logic wr_en;   // store deadline, mark slot valid
    logic clr_en;  // drop slot
  } store_ctrl_t;

endpackage

`default_nettype wire

[hdl/dtt_store.sv]
`default_nettype none

module dtt_store
  import dtt_pkg::*;
#(
  parameter int unsigned SLOTS = SlotsDefault,
  parameter int unsigned IdxW  = $clog2(SLOTS)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire store_ctrl_t      ctrl_i,
  input  wire logic [IdxW-1:0]  addr_i,
  input  wire logic [DlW-1:0]   wr_data_i,
  output logic                  slot_vld_o,
  input  wire logic [IdxW-1:0]  rd_addr_i,
  output logic [DlW-1:0]        rd_data_o,
  output logic                  rd_vld_o
);

  logic [DlW-1:0]   mem [SLOTS];
  logic [SLOTS-1:0] valid_q;
  logic [DlW-1:0]   rd_data_q;
  logic             rd_vld_q;

  // deadline memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  // per-slot valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctrl_i.wr_en) begin
        valid_q[addr_i] <= 1'b1;
      end else if (ctrl_i.clr_en) begin
        valid_q[addr_i] <= 1'b0;
      end
      rd_vld_q <= valid_q[rd_addr_i];
    end
  end

  assign slot_vld_o = valid_q[addr_i];
  assign rd_data_o  = rd_data_q;
  assign rd_vld_o   = rd_vld_q;

endmodule

`default_nettype wire

[hdl/dtt_ms_unit.sv]
`default_nettype none

// Sleep time in ms from the earliest deadline and the current time. Seconds and
// nanoseconds are differenced apart, the nanosecond part is brought into range
// with up to two borrows, then one shared multiplier forms seconds * 1000 and
// the nanosecond part / 1e6 by reciprocal multiplication.
module dtt_ms_unit
  import dtt_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [SecW-1:0] dead_sec_i,
  input  wire logic [NsW-1:0]  dead_nsec_i,
  input  wire logic [SecW-1:0] now_sec_i,
  input  wire logic [NsW-1:0]  now_nsec_i,
  output logic                 done_o,
  output logic [MsW-1:0]       ms_o
);

  typedef enum logic [2:0] {
    M_IDLE, M_BRW_A, M_BRW_B, M_MUL_S, M_MUL_N, M_SUM
  } ms_state_e;

  localparam int unsigned SDiffW = SecW + 2;
  localparam int unsigned NDiffW = NsW + 2;
  localparam int unsigned MulAW  = 32;
  localparam int unsigned MulBW  = 25;
  localparam int unsigned ProdW  = MulAW + MulBW;
  localparam int unsigned QW     = 10;

  // ns / 1e6 == (ns >> 6) / 15625 == ((ns >> 6) * RecipM) >> RecipSh, exact below 2^24
  localparam logic [MulBW-1:0] MsPerS  = 25'd1000;
  localparam logic [MulBW-1:0] RecipM  = 25'd17592187;
  localparam int unsigned      RecipSh = 38;

  ms_state_e         state_q;
  logic [SDiffW-1:0] sdiff_q;
  logic [NDiffW-1:0] ndiff_q;
  logic [ProdW-1:0]  prod_q;
  logic [MsW-1:0]    ms_q;
  logic              late_q;
  logic              done_q;

  logic [MulAW-1:0]  mul_a;
  logic [MulBW-1:0]  mul_b;
  logic [ProdW-1:0]  mul_p;

  // shared multiplier: seconds difference first, then the scaled nanoseconds
  assign mul_a = (state_q == M_MUL_N) ? {8'd0, ndiff_q[NsW-1:6]} : sdiff_q[SecW-1:0];
  assign mul_b = (state_q == M_MUL_N) ? RecipM : MsPerS;
  assign mul_p = {{MulBW{1'b0}}, mul_a} * {{MulAW{1'b0}}, mul_b};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      done_q  <= 1'b0;
      ms_q    <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        M_IDLE: begin
          if (start_i) begin
            sdiff_q <= {2'b00, dead_sec_i} - {2'b00, now_sec_i};
            ndiff_q <= {2'b00, dead_nsec_i} - {2'b00, now_nsec_i};
            state_q <= M_BRW_A;
          end
        end
        // nanosecond borrow, taken up to twice
        M_BRW_A, M_BRW_B: begin
          if (ndiff_q[NDiffW-1]) begin
            ndiff_q <= ndiff_q + NDiffW'(NsPerS);
            sdiff_q <= sdiff_q - SDiffW'(1);
          end
          state_q <= (state_q == M_BRW_A) ? M_BRW_B : M_MUL_S;
        end
        // deadline at or before now sleeps zero
        M_MUL_S: begin
          late_q  <= sdiff_q[SDiffW-1] || ((sdiff_q == '0) && (ndiff_q == '0));
          prod_q  <= mul_p;
          state_q <= M_MUL_N;
        end
        M_MUL_N: begin
          ms_q    <= prod_q[MsW-1:0];
          prod_q  <= mul_p;
          state_q <= M_SUM;
        end
        M_SUM: begin
          ms_q    <= late_q ? '0 : ms_q + MsW'(prod_q[RecipSh +: QW]);
          done_q  <= 1'b1;
          state_q <= M_IDLE;
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign ms_o   = ms_q;

endmodule

`default_nettype wire

[hdl/deadline_timeout_table.sv]
`default_nettype none

// Channel   Dir  tdata fields (low bit up)                              tuser
// s_axis    in   obj_slot, delay_sec, delay_nsec, now_sec, now_nsec      op
// m_axis    out  status, slot_present, any_pending, earliest_slot,       -
//                earliest_sec, earliest_nsec, sleep_ms
//
// Each word runs through these steps before the next one is accepted: accept,
// the nanosecond carry states S_RED_A and S_RED_B, the table update, the minimum
// scan over the deadline memory's single read port, the check, the sleep-time
// unit and the hand-over of the result. With nothing pending the sleep-time unit
// is skipped. s_axis_tready is high only when idle; a finished result waits in
// the output register until m_axis takes it. Reset clears all slots; the deadline
// memory itself is not cleared.
module deadline_timeout_table
  import dtt_pkg::*;
#(
  parameter int unsigned SLOTS = SlotsDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // obj_slot, delay_sec, delay_nsec, now_sec, now_nsec, zero pad
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // op
  input  wire logic                s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // status, slot_present, any_pending, earliest_slot, earliest_sec,
  // earliest_nsec, sleep_ms, zero pad
  output logic [OutDataW-1:0]      m_axis_tdata
);

  localparam int unsigned IdxW = $clog2(SLOTS);
  localparam int unsigned CntW = $clog2(SLOTS + 1);
  localparam int unsigned CmpW = ((IdxW > SlotW) ? IdxW : SlotW) + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_RED_A, S_RED_B, S_UPD, S_SCAN, S_CHK, S_MS, S_OUT
  } state_e;

  state_e          state_q;
  logic            op_q;
  logic [SlotW-1:0] slot_q;
  logic            del_zero_q;
  logic [SecW-1:0] now_sec_q;
  logic [NsW-1:0]  now_nsec_q;
  logic [SecW-1:0] dl_sec_q;
  logic [NsW:0]    dl_ns_q;
  logic            status_q;
  logic            present_q;
  logic            found_q;
  logic [DlW-1:0]  best_q;
  logic [IdxW-1:0] best_slot_q;
  logic [MsW-1:0]  ms_q;
  logic [CntW-1:0] scan_cnt_q;
  logic            cmp_q;
  logic [IdxW-1:0] cmp_idx_q;
  logic            ms_start_q;
  logic            out_valid_q;

  logic            in_range;
  logic [IdxW-1:0] slot_idx;
  logic            issue;
  logic [IdxW-1:0] rd_addr;
  store_ctrl_t     sctrl;
  logic            slot_vld;
  logic [DlW-1:0]  rd_data;
  logic            rd_vld;
  logic            ms_done;
  logic [MsW-1:0]  ms_res;

  assign slot_idx = IdxW'(slot_q);
  assign in_range = CmpW'(slot_q) < CmpW'(SLOTS);
  assign issue    = scan_cnt_q < CntW'(SLOTS);
  assign rd_addr  = issue ? scan_cnt_q[IdxW-1:0] : '0;

  // table update strobes, active in the update state only
  always_comb begin
    sctrl.wr_en  = (state_q == S_UPD) && (op_q == OpSet) && !del_zero_q && in_range;
    sctrl.clr_en = (state_q == S_UPD) && (op_q == OpSet) && del_zero_q && in_range
                   && slot_vld;
  end

  dtt_store #(
    .SLOTS (SLOTS),
    .IdxW  (IdxW)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (sctrl),
    .addr_i     (slot_idx),
    .wr_data_i  ({dl_sec_q, dl_ns_q[NsW-1:0]}),
    .slot_vld_o (slot_vld),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_data),
    .rd_vld_o   (rd_vld)
  );

  dtt_ms_unit u_ms (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (ms_start_q),
    .dead_sec_i  (best_q[DlW-1:NsW]),
    .dead_nsec_i (best_q[NsW-1:0]),
    .now_sec_i   (now_sec_q),
    .now_nsec_i  (now_nsec_q),
    .done_o      (ms_done),
    .ms_o        (ms_res)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      ms_start_q  <= 1'b0;
      cmp_q       <= 1'b0;
      found_q     <= 1'b0;
      scan_cnt_q  <= '0;
    end else begin
      ms_start_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op_q       <= s_axis_tuser;
            slot_q     <= s_axis_tdata[5:0];
            del_zero_q <= (s_axis_tdata[37:6] == '0) && (s_axis_tdata[67:38] == '0);
            now_sec_q  <= s_axis_tdata[99:68];
            now_nsec_q <= s_axis_tdata[129:100];
            dl_sec_q   <= s_axis_tdata[37:6] + s_axis_tdata[99:68];
            dl_ns_q    <= {1'b0, s_axis_tdata[67:38]} + {1'b0, s_axis_tdata[129:100]};
            state_q    <= S_RED_A;
          end
        end
        // nanosecond carry, taken up to twice
        S_RED_A, S_RED_B: begin
          if (dl_ns_q >= {1'b0, NsPerS}) begin
            dl_ns_q  <= dl_ns_q - {1'b0, NsPerS};
            dl_sec_q <= dl_sec_q + 32'd1;
          end
          state_q <= (state_q == S_RED_A) ? S_RED_B : S_UPD;
        end
        S_UPD: begin
          status_q   <= ((op_q == OpSet) && del_zero_q && !(in_range && slot_vld))
                        ? StNotFound : StOk;
          scan_cnt_q <= '0;
          cmp_q      <= 1'b0;
          found_q    <= 1'b0;
          state_q    <= S_SCAN;
        end
        // minimum search, strict compare keeps the lowest slot on ties
        S_SCAN: begin
          if (issue) begin
            scan_cnt_q <= scan_cnt_q + CntW'(1);
          end
          cmp_q     <= issue;
          cmp_idx_q <= rd_addr;
          if (cmp_q && rd_vld && (!found_q || (rd_data < best_q))) begin
            best_q      <= rd_data;
            best_slot_q <= cmp_idx_q;
            found_q     <= 1'b1;
          end
          if (!issue) begin
            state_q <= S_CHK;
          end
        end
        S_CHK: begin
          present_q <= in_range && slot_vld;
          if (found_q) begin
            ms_start_q <= 1'b1;
            state_q    <= S_MS;
          end else begin
            ms_q        <= '0;
            out_valid_q <= 1'b1;
            state_q     <= S_OUT;
          end
        end
        S_MS: begin
          if (ms_done) begin
            ms_q        <= ms_res;
            out_valid_q <= 1'b1;
            state_q     <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            out_valid_q <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;

  // result word, earliest fields zero when nothing is pending
  assign m_axis_tdata = {
    7'd0,
    ms_q,
    found_q ? best_q[NsW-1:0] : {NsW{1'b0}},
    found_q ? best_q[DlW-1:NsW] : {SecW{1'b0}},
    found_q ? SlotW'(best_slot_q) : {SlotW{1'b0}},
    found_q,
    present_q,
    status_q
  };

endmodule

`default_nettype wire
